// File: hw/rtl/alloc_site_escape_classifier_defines.svh
// assertion macros for the allocation site classifier
// no dependencies
`ifndef ALLOC_SITE_ESCAPE_CLASSIFIER_DEFINES_SVH
`define ALLOC_SITE_ESCAPE_CLASSIFIER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define ASEC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define ASEC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/asec_pkg.sv
// shared types and constants for the allocation site classifier
// no dependencies
package asec_pkg;
   localparam int MaxSites  = 256;
   localparam int CountBits = 32;
   localparam int IdxBits   = $clog2(MaxSites);
   localparam int UsedBits  = $clog2(MaxSites + 1);

   typedef logic [2:0]           func_type;
   typedef logic [63:0]          key_type;
   typedef logic [CountBits-1:0] count_type;
   typedef logic [1:0]           region_type;
   typedef logic [UsedBits-1:0]  used_type;

   localparam func_type FuncAlloc   = 3'd0;
   localparam func_type FuncEscape  = 3'd1;
   localparam func_type FuncMigrate = 3'd2;
   localparam func_type FuncUpdate  = 3'd3;
   localparam func_type FuncQuery   = 3'd4;

   localparam region_type RegionLocal  = 2'd0;
   localparam region_type RegionCaller = 2'd1;
   localparam region_type RegionGlobal = 2'd2;

   typedef enum logic [1:0] {
      StIdle,
      StWalk,
      StDone
   } state_type;

   // command passed cell to cell along the chain during the walk
   typedef struct packed {
      logic     active;
      func_type func;
      key_type  key;
   } cmd_type;

   // per cell control from the sequencer
   typedef struct packed {
      logic     insert;
      func_type func;
      key_type  key;
   } ins_type;

   function automatic count_type sat_inc(count_type v);
      return (v == '1) ? v : v + count_type'(1);
   endfunction

   // exact region test on saturating counters
   function automatic region_type classify(count_type a, count_type e);
      logic [CountBits+3:0] e10, a9, e2, a1;
      e10 = {e, 3'b000} + {2'b00, e, 1'b0};
      a9  = {a, 3'b000} + {4'b0000, a};
      e2  = {3'b000, e, 1'b0};
      a1  = {4'b0000, a};
      if (e10 >= a9) return RegionGlobal;
      else if (e2 >= a1) return RegionCaller;
      else return RegionLocal;
   endfunction
endpackage

// File: hw/rtl/asec_if.sv
// valid/ready channel interfaces for the classifier
// depends on asec_pkg
interface asec_req_if;
   logic               valid;
   logic               ready;
   asec_pkg::func_type func;
   asec_pkg::key_type  site_id;
   modport source (output valid, output func, output site_id, input ready);
   modport sink (input valid, input func, input site_id, output ready);
endinterface

interface asec_rsp_if;
   logic                 valid;
   logic                 ready;
   asec_pkg::region_type recommendation;
   logic                 found;
   logic                 dropped;
   asec_pkg::used_type   sites_used;
   modport source (output valid, output recommendation, output found, output dropped,
      output sites_used, input ready);
   modport sink (input valid, input recommendation, input found, input dropped,
      input sites_used, output ready);
endinterface

interface asec_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/asec_cell.sv
// one table entry of the classifier chain: key, counters and region
// depends on asec_pkg
module asec_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 sel,
   input  asec_pkg::cmd_type    cmd_in,
   input  asec_pkg::ins_type    ins,
   input  logic                 hit_in,
   input  asec_pkg::region_type rec_in,
   output asec_pkg::cmd_type    cmd_out,
   output logic                 hit_out,
   output asec_pkg::region_type rec_out
);
   asec_pkg::key_type    key_ff, key_in;
   asec_pkg::count_type  alloc_ff, alloc_in, esc_ff, esc_in, mig_ff, mig_in;
   asec_pkg::region_type reg_ff, reg_in;
   asec_pkg::cmd_type    cmd_ff;
   logic                 hit_ff, match;
   asec_pkg::region_type rec_ff;

   // sel marks the cell as holding a valid entry
   assign match = cmd_in.active && sel && (key_ff == cmd_in.key);

   always_comb begin
      key_in   = key_ff;
      alloc_in = alloc_ff;
      esc_in   = esc_ff;
      mig_in   = mig_ff;
      reg_in   = reg_ff;
      if (ins.insert) begin
         key_in   = ins.key;
         alloc_in = '0;
         esc_in   = '0;
         mig_in   = '0;
         reg_in   = asec_pkg::RegionLocal;
      end
      if (ins.insert || match) begin
         case (ins.insert ? ins.func : cmd_in.func)
            asec_pkg::FuncAlloc:   alloc_in = asec_pkg::sat_inc(ins.insert ? '0 : alloc_ff);
            asec_pkg::FuncEscape:  esc_in   = asec_pkg::sat_inc(ins.insert ? '0 : esc_ff);
            asec_pkg::FuncMigrate: mig_in   = asec_pkg::sat_inc(ins.insert ? '0 : mig_ff);
            default: ;
         endcase
      end
      if (cmd_in.active && sel && cmd_in.func == asec_pkg::FuncUpdate && alloc_ff != '0)
         reg_in = asec_pkg::classify(alloc_ff, esc_ff);
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      alloc_ff <= alloc_in;
      esc_ff   <= esc_in;
      mig_ff   <= mig_in;
      reg_ff   <= reg_in;
      rec_ff   <= match ? reg_ff : rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         cmd_ff <= cmd_in;
         hit_ff <= match || hit_in;
      end
   end

   assign cmd_out = cmd_ff;
   assign hit_out = hit_ff;
   assign rec_out = rec_ff;
endmodule

// File: hw/rtl/asec_seq.sv
// sequencer: accepts words, walks the chain, inserts and answers
// depends on asec_pkg
module asec_seq (
   input  logic                 clock,
   input  logic                 reset,
   asec_req_if.sink             req,
   asec_rsp_if.source           rsp,
   asec_csr_if.sink             csr,
   input  logic                 hit_end,
   input  asec_pkg::region_type rec_end,
   output asec_pkg::cmd_type    cmd,
   output asec_pkg::used_type   used,
   output logic                 ins_en,
   output asec_pkg::func_type   ins_func,
   output asec_pkg::key_type    ins_key
);
   localparam int CntBits = $clog2(asec_pkg::MaxSites + 2);
   asec_pkg::state_type  st_ff, st_in;
   logic                 en_ff;
   asec_pkg::func_type   func_ff;
   asec_pkg::key_type    key_ff;
   logic [CntBits-1:0]   cnt_ff, cnt_in;
   asec_pkg::used_type   used_ff, used_in;
   logic                 rv_ff, rv_in;
   asec_pkg::region_type rrec_ff, rrec_in;
   logic                 rfound_ff, rfound_in, rdrop_ff, rdrop_in;
   logic                 take, is_event;

   assign take      = req.valid && req.ready;
   assign req.ready = (st_ff == asec_pkg::StIdle) && !rv_ff;
   assign csr.ready = 1'b1;
   assign is_event  = func_ff == asec_pkg::FuncAlloc || func_ff == asec_pkg::FuncEscape
      || func_ff == asec_pkg::FuncMigrate;

   assign cmd.active = (st_ff == asec_pkg::StWalk) && cnt_ff == '0 && en_ff;
   assign cmd.func   = func_ff;
   assign cmd.key    = key_ff;
   assign used       = used_ff;
   assign ins_func   = func_ff;
   assign ins_key    = key_ff;

   always_comb begin
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      used_in   = used_ff;
      rv_in     = rv_ff && !rsp.ready;
      rrec_in   = rrec_ff;
      rfound_in = rfound_ff;
      rdrop_in  = rdrop_ff;
      ins_en    = 1'b0;
      case (st_ff)
         asec_pkg::StIdle: begin
            if (take) begin
               st_in  = asec_pkg::StWalk;
               cnt_in = '0;
            end
         end
         asec_pkg::StWalk: begin
            // wait for the command to reach the chain end
            cnt_in = cnt_ff + CntBits'(1);
            if (cnt_ff == CntBits'(asec_pkg::MaxSites - 1)) st_in = asec_pkg::StDone;
         end
         asec_pkg::StDone: begin
            st_in     = asec_pkg::StIdle;
            rv_in     = 1'b1;
            rrec_in   = asec_pkg::RegionLocal;
            rfound_in = 1'b0;
            rdrop_in  = 1'b0;
            if (is_event) begin
               if (!en_ff) rdrop_in = 1'b1;
               else if (hit_end) rfound_in = 1'b1;
               else if (used_ff < asec_pkg::used_type'(asec_pkg::MaxSites)) begin
                  ins_en  = 1'b1;
                  used_in = used_ff + asec_pkg::used_type'(1);
               end else rdrop_in = 1'b1;
            end else if (func_ff == asec_pkg::FuncQuery && en_ff && hit_end) begin
               rfound_in = 1'b1;
               rrec_in   = rec_end;
            end
         end
         default: st_in = asec_pkg::StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= asec_pkg::StIdle;
         cnt_ff  <= '0;
         used_ff <= '0;
         rv_ff   <= 1'b0;
         en_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         used_ff <= used_in;
         rv_ff   <= rv_in;
         if (csr.valid) en_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         func_ff <= req.func;
         key_ff  <= req.site_id;
      end
      rrec_ff   <= rrec_in;
      rfound_ff <= rfound_in;
      rdrop_ff  <= rdrop_in;
   end

   assign rsp.valid          = rv_ff;
   assign rsp.recommendation = rrec_ff;
   assign rsp.found          = rfound_ff;
   assign rsp.dropped        = rdrop_ff;
   assign rsp.sites_used     = used_ff;
endmodule

// File: hw/rtl/alloc_site_escape_classifier.sv
// top level of the allocation site escape classifier
// depends on asec_pkg, asec_if, asec_seq and asec_cell
//
// for each accepted word the command ripples through a chain of MaxSites
// cells, one cell a cycle, each cell comparing its key, counting events and
// reclassifying on update; the hit flag and stored region come out of the
// last cell and the sequencer then inserts a new entry at the fill count
// when needed. one word is in flight at a time; the result sits in an output
// register and the next word is taken once it has been delivered. no
// clearing pass after reset
module alloc_site_escape_classifier (
   input  logic clock,
   input  logic reset,
   asec_req_if.sink   req,
   asec_rsp_if.source rsp,
   asec_csr_if.sink   csr
);
   asec_pkg::cmd_type    cmd_chain [asec_pkg::MaxSites+1];
   logic                 hit_chain [asec_pkg::MaxSites+1];
   asec_pkg::region_type rec_chain [asec_pkg::MaxSites+1];
   asec_pkg::used_type   used;
   logic                 ins_en;
   asec_pkg::func_type   ins_func;
   asec_pkg::key_type    ins_key;

   // sequencer and fill count
   asec_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .csr      (csr),
      .hit_end  (hit_chain[asec_pkg::MaxSites]),
      .rec_end  (rec_chain[asec_pkg::MaxSites]),
      .cmd      (cmd_chain[0]),
      .used     (used),
      .ins_en   (ins_en),
      .ins_func (ins_func),
      .ins_key  (ins_key)
   );

   assign hit_chain[0] = 1'b0;
   assign rec_chain[0] = asec_pkg::RegionLocal;

   // row of cells, entry i lives in cell i
   for (genvar i = 0; i < asec_pkg::MaxSites; i++) begin : g_cell
      asec_pkg::ins_type ins;
      logic              sel;
      assign sel        = asec_pkg::used_type'(i) < used;
      assign ins.insert = ins_en && (used == asec_pkg::used_type'(i));
      assign ins.func   = ins_func;
      assign ins.key    = ins_key;
      asec_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .sel     (sel),
         .cmd_in  (cmd_chain[i]),
         .ins     (ins),
         .hit_in  (hit_chain[i]),
         .rec_in  (rec_chain[i]),
         .cmd_out (cmd_chain[i+1]),
         .hit_out (hit_chain[i+1]),
         .rec_out (rec_chain[i+1])
      );
   end
endmodule

// File: hw/rtl/asec_checker.sv
// port level checks for the classifier
// depends on asec_pkg and the defines header
`include "alloc_site_escape_classifier_defines.svh"
module asec_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input asec_pkg::region_type rsp_recommendation,
   input logic                 rsp_found,
   input logic                 rsp_dropped,
   input asec_pkg::used_type   rsp_sites_used
);
   `ASEC_ASSERT_IMP(a_rec_range, clock, reset, rsp_valid, rsp_recommendation != 2'd3)
   `ASEC_ASSERT_IMP(a_found_drop, clock, reset, rsp_valid, !(rsp_found && rsp_dropped))
   `ASEC_ASSERT_IMP(a_used_max, clock, reset, rsp_valid,
      rsp_sites_used <= asec_pkg::used_type'(asec_pkg::MaxSites))
   `ASEC_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !rsp_valid)
   `ASEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind alloc_site_escape_classifier asec_checker u_asec_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_recommendation (rsp.recommendation),
   .rsp_found          (rsp.found),
   .rsp_dropped        (rsp.dropped),
   .rsp_sites_used     (rsp.sites_used)
);
